@@ rtl/core/gregorian_date_stepper_assert.svh @@
// Assertion macros shared by the date stepper checker.
`ifndef GREGORIAN_DATE_STEPPER_ASSERT_SVH
`define GREGORIAN_DATE_STEPPER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gds_pkg.sv @@
// Types, constants and calendar tables for the Gregorian date stepper.
package gds_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADV  = 2'd1,
    OP_RET  = 2'd2,
    OP_DIST = 2'd3
  } gds_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q100,
    ST_R100,
    ST_YDAYS,
    ST_SUM1,
    ST_SUM2,
    ST_EVAL,
    ST_SAT,
    ST_DIV,
    ST_MON,
    ST_DONE
  } gds_state_t;

  localparam logic [3:0]  DEF_MONTH     = 4'd1;
  localparam logic [4:0]  DEF_DAY       = 5'd1;
  localparam logic [13:0] DEF_YEAR      = 14'd1900;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [3:0]  MONTH_MAX     = 4'd12;
  // Day numbers, counted from 1 January of year 1 as day 0.
  localparam logic [21:0] DEF_SER       = 22'd693595;
  localparam logic [21:0] LAST_SER      = 22'd3652058;
  // floor(p / 100) = (p * 5243) >> 19, exact for every 14-bit p.
  localparam logic [12:0] RECIP100      = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [12:0] CENTURY       = 13'd100;
  localparam logic [12:0] DAYS_PER_YEAR = 13'd365;
  localparam logic [3:0]  LAST_STEP     = 4'd13;

  function automatic logic [4:0] gds_dim(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // Days before the first of month m in a common year.
  function automatic logic [8:0] gds_cum(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Restoring steps of the year decomposition: five for 400-year cycles,
  // two for centuries, five for 4-year groups and two for single years.
  function automatic logic [21:0] gds_step_days(input logic [3:0] idx);
    logic [21:0] d;
    case (idx)
      4'd0:    d = 22'd2337552;
      4'd1:    d = 22'd1168776;
      4'd2:    d = 22'd584388;
      4'd3:    d = 22'd292194;
      4'd4:    d = 22'd146097;
      4'd5:    d = 22'd73048;
      4'd6:    d = 22'd36524;
      4'd7:    d = 22'd23376;
      4'd8:    d = 22'd11688;
      4'd9:    d = 22'd5844;
      4'd10:   d = 22'd2922;
      4'd11:   d = 22'd1461;
      4'd12:   d = 22'd730;
      4'd13:   d = 22'd365;
      default: d = 22'd0;
    endcase
    return d;
  endfunction

  function automatic logic [13:0] gds_step_years(input logic [3:0] idx);
    logic [13:0] y;
    case (idx)
      4'd0:    y = 14'd6400;
      4'd1:    y = 14'd3200;
      4'd2:    y = 14'd1600;
      4'd3:    y = 14'd800;
      4'd4:    y = 14'd400;
      4'd5:    y = 14'd200;
      4'd6:    y = 14'd100;
      4'd7:    y = 14'd64;
      4'd8:    y = 14'd32;
      4'd9:    y = 14'd16;
      4'd10:   y = 14'd8;
      4'd11:   y = 14'd4;
      4'd12:   y = 14'd2;
      4'd13:   y = 14'd1;
      default: y = 14'd0;
    endcase
    return y;
  endfunction

endpackage

@@ rtl/core/gregorian_date_stepper.sv @@
// Gregorian date stepper: stored date with set, advance, retreat and distance operations.
//
// The block holds one date and its day number. Each input item carries an
// operation in in_tuser and a date and day count in in_tdata; each produces
// exactly one result item with the stored date afterwards and the flags of
// that operation. One item is worked on at a time and in_tready is low while
// it is. Set and distance offer their result after the multiply steps that
// turn the input date into a day number on one shared 14 by 13 bit multiplier.
// Advance and retreat offer theirs after fourteen restoring steps split the day
// number into 400-year, century, 4-year and single-year parts and a walk of up
// to twelve steps finds the month, all on one shared subtract-and-compare unit.
// A result waiting in the output register does not stop the next item from
// being accepted; only its delivery waits.
module gregorian_date_stepper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: in_month[3:0], in_day[8:4], in_year[22:9],
  // day_count[38:23], zero fill[39]
  input  logic [39:0] in_tdata,
  // in_tuser, from bit 0: op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: cur_month[3:0], cur_day[8:4], cur_year[22:9],
  // distance[44:23], stored_earlier[45], set_valid[46], range_error[47]
  output logic [47:0] out_tdata
);
  import gds_pkg::*;

  gds_state_t  state_r, state_nxt;
  gds_op_t     op_r, op_nxt;
  logic [3:0]  im_r, im_nxt;
  logic [4:0]  id_r, id_nxt;
  logic [13:0] iy_r, iy_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [13:0] year_r, year_nxt;
  logic [21:0] ser_r, ser_nxt;

  logic [21:0] acc_r, acc_nxt;
  logic [26:0] prod_r, prod_nxt;
  logic [7:0]  q100_r, q100_nxt;
  logic        leap_r, leap_nxt;
  logic        ok_r, ok_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [8:0]  code_r, code_nxt;
  logic [13:0] yacc_r, yacc_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic [21:0] dist_r, dist_nxt;
  logic        earl_r, earl_nxt;
  logic        sv_r, sv_nxt;
  logic        rerr_r, rerr_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [47:0] out_data_r, out_data_nxt;

  logic        accept;
  logic        out_free;
  logic [13:0] p;
  logic [13:0] mul_a;
  logic [12:0] mul_b;
  logic [26:0] mul_p;
  logic [13:0] r100;
  logic        leap_in;
  logic [21:0] sub_b;
  logic [22:0] sub_d;
  logic        take;
  logic        leap_dec;
  logic [4:0]  dimv;
  logic [22:0] sum_adv;
  logic [21:0] other;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Year minus one: the day number counts whole years before the date.
  assign p = iy_r - 14'd1;

  // Shared multiplier for the day number of an input date.
  always_comb begin
    case (state_r)
      ST_Q100: begin
        mul_a = p;
        mul_b = RECIP100;
      end
      ST_R100: begin
        mul_a = {6'b0, prod_r[RECIP_SHIFT +: 8]};
        mul_b = CENTURY;
      end
      ST_YDAYS: begin
        mul_a = p;
        mul_b = DAYS_PER_YEAR;
      end
      default: begin
        mul_a = p;
        mul_b = DAYS_PER_YEAR;
      end
    endcase
  end
  assign mul_p = {13'b0, mul_a} * {14'b0, mul_b};

  // The year is a leap year when p ends in 3 mod 4 and is not 99 mod 100,
  // unless its century count is 3 mod 4.
  assign r100    = p - prod_r[13:0];
  assign leap_in = (p[1:0] == 2'd3) && ((r100 != 14'd99) || (q100_r[1:0] == 2'd3));

  // The same rule read from the decomposition: code holds the century,
  // 4-year and single-year counts.
  assign leap_dec = (code_r[1:0] == 2'd3) &&
                    ((code_r[6:2] != 5'd24) || (code_r[8:7] == 2'd3));
  assign dimv     = gds_dim(mon_r, leap_dec);

  // Shared subtract-and-compare unit for the decomposition and month walk.
  assign sub_b = (state_r == ST_MON) ? {17'b0, dimv} : gds_step_days(step_r);
  assign sub_d = {1'b0, acc_r} - {1'b0, sub_b};
  assign take  = !sub_d[22];

  assign sum_adv = {1'b0, ser_r} + {7'b0, cnt_r};
  assign other   = ok_r ? acc_r : DEF_SER;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((gds_op_t'(in_tuser) == OP_ADV) || (gds_op_t'(in_tuser) == OP_RET)) begin
            state_nxt = ST_SAT;
          end else begin
            state_nxt = ST_Q100;
          end
        end
      end
      ST_Q100:  state_nxt = ST_R100;
      ST_R100:  state_nxt = ST_YDAYS;
      ST_YDAYS: state_nxt = ST_SUM1;
      ST_SUM1:  state_nxt = ST_SUM2;
      ST_SUM2:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_DONE;
      ST_SAT:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if (!((mon_r < MONTH_MAX) && take)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    im_nxt    = im_r;
    id_nxt    = id_r;
    iy_nxt    = iy_r;
    cnt_nxt   = cnt_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    ser_nxt   = ser_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    q100_nxt  = q100_r;
    leap_nxt  = leap_r;
    ok_nxt    = ok_r;
    step_nxt  = step_r;
    code_nxt  = code_r;
    yacc_nxt  = yacc_r;
    mon_nxt   = mon_r;
    dist_nxt  = dist_r;
    earl_nxt  = earl_r;
    sv_nxt    = sv_r;
    rerr_nxt  = rerr_r;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = gds_op_t'(in_tuser);
          im_nxt   = in_tdata[3:0];
          id_nxt   = in_tdata[8:4];
          iy_nxt   = in_tdata[22:9];
          cnt_nxt  = in_tdata[38:23];
          dist_nxt = 22'd0;
          earl_nxt = 1'b0;
          sv_nxt   = 1'b0;
          rerr_nxt = 1'b0;
        end
      end
      ST_Q100: begin
        prod_nxt = mul_p;
      end
      ST_R100: begin
        q100_nxt = prod_r[RECIP_SHIFT +: 8];
        prod_nxt = mul_p;
      end
      ST_YDAYS: begin
        leap_nxt = leap_in;
        prod_nxt = mul_p;
      end
      ST_SUM1: begin
        acc_nxt = prod_r[21:0] + {10'b0, p[13:2]} - {14'b0, q100_r} +
                  {16'b0, q100_r[7:2]};
      end
      ST_SUM2: begin
        acc_nxt = acc_r + {13'b0, gds_cum(im_r)} +
                  {21'b0, (leap_r && (im_r > 4'd2))} + {17'b0, id_r} - 22'd1;
        ok_nxt  = (im_r >= 4'd1) && (im_r <= MONTH_MAX) &&
                  (iy_r >= 14'd1) && (iy_r <= YEAR_MAX) &&
                  (id_r >= 5'd1) && (id_r <= gds_dim(im_r, leap_r));
      end
      ST_EVAL: begin
        if (op_r == OP_SET) begin
          if (ok_r) begin
            month_nxt = im_r;
            day_nxt   = id_r;
            year_nxt  = iy_r;
            ser_nxt   = acc_r;
            sv_nxt    = 1'b1;
          end else begin
            month_nxt = DEF_MONTH;
            day_nxt   = DEF_DAY;
            year_nxt  = DEF_YEAR;
            ser_nxt   = DEF_SER;
          end
        end else begin
          if (ser_r < other) begin
            dist_nxt = other - ser_r;
            earl_nxt = 1'b1;
          end else begin
            dist_nxt = ser_r - other;
          end
        end
      end
      ST_SAT: begin
        if (op_r == OP_ADV) begin
          if (sum_adv > {1'b0, LAST_SER}) begin
            acc_nxt  = LAST_SER;
            rerr_nxt = 1'b1;
          end else begin
            acc_nxt = sum_adv[21:0];
          end
        end else begin
          if ({6'b0, cnt_r} > ser_r) begin
            acc_nxt  = 22'd0;
            rerr_nxt = 1'b1;
          end else begin
            acc_nxt = ser_r - {6'b0, cnt_r};
          end
        end
        step_nxt = 4'd0;
        code_nxt = 9'd0;
        yacc_nxt = 14'd1;
      end
      ST_DIV: begin
        if (take) begin
          acc_nxt  = sub_d[21:0];
          yacc_nxt = yacc_r + gds_step_years(step_r);
        end
        // The 400-year bits shift out; the last nine hold what the leap rule needs.
        code_nxt = {code_r[7:0], take};
        step_nxt = step_r + 4'd1;
        mon_nxt  = 4'd1;
        // Store the new day number once the decomposition has started.
        ser_nxt  = (step_r == 4'd0) ? acc_r : ser_r;
      end
      ST_MON: begin
        if ((mon_r < MONTH_MAX) && take) begin
          acc_nxt = sub_d[21:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          month_nxt = mon_r;
          day_nxt   = acc_r[4:0] + 5'd1;
          year_nxt  = yacc_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {rerr_r, sv_r, earl_r, dist_r, year_r, day_r, month_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      month_r      <= DEF_MONTH;
      day_r        <= DEF_DAY;
      year_r       <= DEF_YEAR;
      ser_r        <= DEF_SER;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      month_r      <= month_nxt;
      day_r        <= day_nxt;
      year_r       <= year_nxt;
      ser_r        <= ser_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    im_r       <= im_nxt;
    id_r       <= id_nxt;
    iy_r       <= iy_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    q100_r     <= q100_nxt;
    leap_r     <= leap_nxt;
    ok_r       <= ok_nxt;
    step_r     <= step_nxt;
    code_r     <= code_nxt;
    yacc_r     <= yacc_nxt;
    mon_r      <= mon_nxt;
    dist_r     <= dist_nxt;
    earl_r     <= earl_nxt;
    sv_r       <= sv_nxt;
    rerr_r     <= rerr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/gds_checker.sv @@
// Port-level checker for the date stepper, bound to the top level.
`include "gregorian_date_stepper_assert.svh"

module gds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import gds_pkg::*;

  logic        item_in;
  logic        out_stall;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [13:0] out_year;
  logic [21:0] out_dist;
  logic        out_earl;
  logic        out_sv;
  logic        out_rerr;
  logic        date_fits;
  logic        flags_fit;

  assign item_in   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_month = out_tdata[3:0];
  assign out_day   = out_tdata[8:4];
  assign out_year  = out_tdata[22:9];
  assign out_dist  = out_tdata[44:23];
  assign out_earl  = out_tdata[45];
  assign out_sv    = out_tdata[46];
  assign out_rerr  = out_tdata[47];

  assign date_fits = (out_month >= 4'd1) && (out_month <= MONTH_MAX) && (out_day >= 5'd1) &&
                     (out_year >= 14'd1) && (out_year <= YEAR_MAX);
  assign flags_fit = !(out_sv && out_rerr) && !(out_sv && out_earl) &&
                     !(out_rerr && (out_dist != 22'd0));

  // A stalled result item stays offered and unchanged.
  `GDS_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled item changed")

  // One item at a time: ready drops right after an item is taken.
  `GDS_ASSERT_NXT(a_one_at_a_time, item_in, !in_tready, "second item taken while busy")

  // Every delivered date has a month in range, a day of at least one and a year within the year range.
  `GDS_ASSERT_IMP(a_date_range, out_tvalid, date_fits, "result date out of range")

  // The set flag never appears with the range-error or earlier flag, and a range error never comes with a distance.
  `GDS_ASSERT_IMP(a_flags_apart, out_tvalid, flags_fit, "flags of different operations together")

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (.*);

@@ test/gregorian_date_stepper_checker.sv @@
// Checker for the date stepper: predicts each result item and compares it with the output.
module gregorian_date_stepper_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // in_tdata, from bit 0: in_month[3:0], in_day[8:4], in_year[22:9],
  // day_count[38:23], zero fill[39]
  input  logic [39:0] in_tdata,
  // in_tuser, from bit 0: op[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: cur_month[3:0], cur_day[8:4], cur_year[22:9],
  // distance[44:23], stored_earlier[45], set_valid[46], range_error[47]
  input  logic [47:0] out_tdata,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import gds_pkg::*;

  typedef struct packed {
    logic        range_error;
    logic        set_valid;
    logic        stored_earlier;
    logic [21:0] distance;
    logic [13:0] year;
    logic [4:0]  day;
    logic [3:0]  month;
  } date_result_t;

  date_result_t expected_dates_q[$];
  logic [3:0]   date_month;
  logic [4:0]   date_day;
  logic [13:0]  date_year;

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      2:             n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic bit date_valid(input int unsigned m, input int unsigned d,
                                    input int unsigned y);
    if (m < 1 || m > 32'(MONTH_MAX) || y < 1 || y > 32'(YEAR_MAX)) begin
      return 1'b0;
    end
    return d >= 1 && d <= month_days(m, y);
  endfunction

  // Days since 1 January of year 1.
  function automatic int unsigned day_number(input int unsigned m, input int unsigned d,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) begin
      n += month_days(k, y);
    end
    return n + d - 1;
  endfunction

  function automatic void load_day_number(input int unsigned n);
    int unsigned q400, r, c100, q4, y1, y, m;
    q400 = n / 146097;
    r    = n % 146097;
    c100 = r / 36524;
    // The last day of a 400-year cycle would otherwise land in a fifth century.
    if (c100 > 3) begin
      c100 = 3;
    end
    r  -= c100 * 36524;
    q4  = r / 1461;
    r   = r % 1461;
    y1  = r / 365;
    if (y1 > 3) begin
      y1 = 3;
    end
    r -= y1 * 365;
    y  = q400 * 400 + c100 * 100 + q4 * 4 + y1 + 1;
    m  = 1;
    while (m < 12 && r >= month_days(m, y)) begin
      r -= month_days(m, y);
      m++;
    end
    date_year  = 14'(y);
    date_month = 4'(m);
    date_day   = 5'(r + 1);
  endfunction

  task automatic predict_date(input gds_op_t op, input int unsigned m, input int unsigned d,
                              input int unsigned y, input int unsigned cnt,
                              output date_result_t res);
    int unsigned now_num;
    int unsigned last_num;
    int unsigned other;
    res      = '0;
    now_num  = day_number(32'(date_month), 32'(date_day), 32'(date_year));
    last_num = day_number(32'(MONTH_MAX), 31, 32'(YEAR_MAX));
    case (op)
      OP_SET: begin
        if (date_valid(m, d, y)) begin
          date_month    = 4'(m);
          date_day      = 5'(d);
          date_year     = 14'(y);
          res.set_valid = 1'b1;
        end else begin
          date_month = DEF_MONTH;
          date_day   = DEF_DAY;
          date_year  = DEF_YEAR;
        end
      end
      OP_ADV: begin
        if (now_num + cnt > last_num) begin
          load_day_number(last_num);
          res.range_error = 1'b1;
        end else begin
          load_day_number(now_num + cnt);
        end
      end
      OP_RET: begin
        if (cnt > now_num) begin
          load_day_number(0);
          res.range_error = 1'b1;
        end else begin
          load_day_number(now_num - cnt);
        end
      end
      default: begin
        if (!date_valid(m, d, y)) begin
          m = 32'(DEF_MONTH);
          d = 32'(DEF_DAY);
          y = 32'(DEF_YEAR);
        end
        other = day_number(m, d, y);
        if (now_num < other) begin
          res.distance       = 22'(other - now_num);
          res.stored_earlier = 1'b1;
        end else begin
          res.distance = 22'(now_num - other);
        end
      end
    endcase
    res.month = date_month;
    res.day   = date_day;
    res.year  = date_year;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input date_result_t got);
    date_result_t want;
    if (expected_dates_q.size() == 0) begin
      report_mismatch("result item with nothing pending, tdata", longint'(got), 0);
      return;
    end
    want = expected_dates_q.pop_front();
    if (got.month !== want.month) begin
      report_mismatch("cur_month", longint'(got.month), longint'(want.month));
    end
    if (got.day !== want.day) begin
      report_mismatch("cur_day", longint'(got.day), longint'(want.day));
    end
    if (got.year !== want.year) begin
      report_mismatch("cur_year", longint'(got.year), longint'(want.year));
    end
    if (got.distance !== want.distance) begin
      report_mismatch("distance", longint'(got.distance), longint'(want.distance));
    end
    if (got.stored_earlier !== want.stored_earlier) begin
      report_mismatch("stored_earlier", longint'(got.stored_earlier),
                      longint'(want.stored_earlier));
    end
    if (got.set_valid !== want.set_valid) begin
      report_mismatch("set_valid", longint'(got.set_valid), longint'(want.set_valid));
    end
    if (got.range_error !== want.range_error) begin
      report_mismatch("range_error", longint'(got.range_error), longint'(want.range_error));
    end
  endtask

  always @(posedge clk) begin
    date_result_t res;
    if (!rst_n) begin
      date_month = DEF_MONTH;
      date_day   = DEF_DAY;
      date_year  = DEF_YEAR;
      expected_dates_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // The result leaving now always belongs to an older item than one entering now.
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        predict_date(gds_op_t'(in_tuser), 32'(in_tdata[3:0]), 32'(in_tdata[8:4]),
                     32'(in_tdata[22:9]), 32'(in_tdata[38:23]), res);
        expected_dates_q.push_back(res);
      end
      pending <= expected_dates_q.size();
    end
  end

endmodule

@@ test/gregorian_date_stepper_tb.sv @@
// Testbench top for the date stepper: clock, reset, stimulus, watchdog and verdict.
module gregorian_date_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gds_pkg::*;

  localparam int IDLE_PCT       = 17;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  int          pending;
  int          fail_count;
  int          quiet_cycles = 0;
  bit          steady       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gregorian_date_stepper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gregorian_date_stepper_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_date_op(input gds_op_t op, input logic [3:0] m, input logic [4:0] d,
                              input logic [13:0] y, input logic [15:0] cnt);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, cnt, y, d, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    // One edge first, so that the item just accepted is counted as pending.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    gds_op_t     op;
    int unsigned m, d, y, cnt, pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) op = OP_SET;
    else if (pick < 50) op = OP_ADV;
    else if (pick < 80) op = OP_RET;
    else op = OP_DIST;
    // Years near both ends make saturation frequent; century years test the leap rule.
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 4);
      1:       y = $urandom_range(9995, 9999);
      2:       y = $urandom_range(1, 99) * 100;
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 28) : $urandom_range(29, 31);
    if ($urandom_range(0, 99) < 10 || op == OP_ADV || op == OP_RET) begin
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
      y = $urandom_range(0, 16383);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cnt = $urandom_range(0, 40);
      4, 5, 6:    cnt = $urandom_range(0, 1000);
      default:    cnt = $urandom_range(0, 65535);
    endcase
    send_date_op(op, 4'(m), 5'(d), 14'(y), 16'(cnt));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Distance from the reset date to itself, then the leap rule at its three levels.
    send_date_op(OP_DIST, 4'd1, 5'd1, 14'd1900, 16'd0);
    send_date_op(OP_SET, 4'd2, 5'd29, 14'd2000, 16'd0);
    send_date_op(OP_ADV, 4'd0, 5'd0, 14'd0, 16'd0);
    send_date_op(OP_SET, 4'd2, 5'd29, 14'd1900, 16'd0);
    send_date_op(OP_SET, 4'd2, 5'd29, 14'd2024, 16'd0);
    send_date_op(OP_ADV, 4'd0, 5'd0, 14'd0, 16'd1);
    send_date_op(OP_RET, 4'd0, 5'd0, 14'd0, 16'd1);
    // Invalid set dates fall back to the default date.
    send_date_op(OP_SET, 4'd0, 5'd15, 14'd2020, 16'd0);
    send_date_op(OP_SET, 4'd13, 5'd1, 14'd2020, 16'd0);
    send_date_op(OP_SET, 4'd15, 5'd31, 14'd16383, 16'd65535);
    send_date_op(OP_SET, 4'd4, 5'd31, 14'd2020, 16'd0);
    send_date_op(OP_SET, 4'd6, 5'd0, 14'd2020, 16'd0);
    send_date_op(OP_SET, 4'd1, 5'd1, 14'd0, 16'd0);
    send_date_op(OP_SET, 4'd12, 5'd31, 14'd10000, 16'd0);
    // Saturation at the top, then the distance back to the first day.
    send_date_op(OP_SET, 4'd12, 5'd31, 14'd9999, 16'd0);
    send_date_op(OP_ADV, 4'd0, 5'd0, 14'd0, 16'd0);
    send_date_op(OP_ADV, 4'd15, 5'd31, 14'd16383, 16'd1);
    send_date_op(OP_DIST, 4'd1, 5'd1, 14'd1, 16'd0);
    // Saturation at the bottom and the widest distance forwards.
    send_date_op(OP_SET, 4'd1, 5'd1, 14'd1, 16'd0);
    send_date_op(OP_RET, 4'd0, 5'd0, 14'd0, 16'd1);
    send_date_op(OP_DIST, 4'd12, 5'd31, 14'd9999, 16'd0);
    send_date_op(OP_ADV, 4'd0, 5'd0, 14'd0, 16'd65535);
    send_date_op(OP_RET, 4'd0, 5'd0, 14'd0, 16'd65535);
    send_date_op(OP_DIST, 4'd2, 5'd30, 14'd2000, 16'd0);
    send_date_op(OP_SET, 4'd12, 5'd31, 14'd1999, 16'd0);
    send_date_op(OP_ADV, 4'd0, 5'd0, 14'd0, 16'd60);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 400 && i < 600);
      if (i == 800) begin
        wait_for_results();
      end
      send_random_op();
    end
    steady = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
